// ===== design/mtt_pkg.sv =====
// mtt_pkg: shared widths, operation codes and controller/datapath bundles
// for the microsecond tick timer. No dependencies.

package mtt_pkg;

    // Counter width and the widths that follow from it
    localparam int CNT_W      = 32;
    localparam int CPU_W      = 10;
    localparam int REQ_W      = 31;
    localparam int ELAP_W     = 32;
    localparam int OP_W       = 2;
    localparam int MUL_W      = REQ_W + CPU_W;
    localparam int PX_W       = MUL_W + CNT_W;
    localparam int DIV_W      = CNT_W + 1;
    localparam int DIV_CNT_W  = $clog2(DIV_W);
    localparam int QX_W       = DIV_W + ELAP_W;
    localparam logic [CPU_W-1:0] CPU_RESET = CPU_W'(1);

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_SET  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;
    localparam logic [OP_W-1:0] OP_ACK  = 2'd3;

    // Result word source
    typedef enum logic [1:0] {
        OSEL_PLAIN = 2'd0,
        OSEL_SET   = 2'd1,
        OSEL_READ  = 2'd2
    } osel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic  tick;
        logic  ack;
        logic  set_load;
        logic  set_commit;
        logic  rd_load;
        logic  rd_adjust;
        logic  div_step;
        logic  out_load;
        osel_t out_sel;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic div_last;
    } sts_t;

endpackage

// ===== design/mtt_ctrl.sv =====
// mtt_ctrl: sequencing state machine and result-word valid for the tick timer.
// Depends on mtt_pkg for command/status bundles and operation codes.

module mtt_ctrl
    import mtt_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [OP_W-1:0] s_op,
    output logic            m_valid,
    input  logic            m_ready,
    input  sts_t            sts,
    output cmd_t            cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SET  = 5'b00010,
        ST_ADJ  = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_RD   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   s_fire;

    // Output slot is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;

    // Decode state and incoming word into datapath commands
    always_comb begin
        cmd        = '0;
        cmd.out_sel = OSEL_PLAIN;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    case (s_op)
                        OP_TICK: begin
                            cmd.tick     = 1'b1;
                            cmd.out_load = 1'b1;
                        end
                        OP_SET: begin
                            cmd.set_load = 1'b1;
                            state_next   = ST_SET;
                        end
                        OP_READ: begin
                            cmd.rd_load = 1'b1;
                            state_next  = ST_ADJ;
                        end
                        OP_ACK: begin
                            cmd.ack      = 1'b1;
                            cmd.out_load = 1'b1;
                        end
                        default: begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_SET: begin
                if (out_free) begin
                    cmd.set_commit = 1'b1;
                    cmd.out_load   = 1'b1;
                    cmd.out_sel    = OSEL_SET;
                    state_next     = ST_IDLE;
                end
            end
            ST_ADJ: begin
                cmd.rd_adjust = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OSEL_READ;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result word until taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // A result is never written over one still waiting
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> out_free)
        else $error("result word overwritten before it was taken");

    // A read goes through the adjust step and then the divider
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_op == OP_READ) |=> (state_reg == ST_ADJ) ##1 (state_reg == ST_DIV))
        else $error("read did not enter the divider");

    // No new word is taken while an operation is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while busy");

    // Short operations deliver their result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_op == OP_TICK || s_op == OP_ACK)) |=> m_valid_reg)
        else $error("tick or acknowledge result missing");

endmodule

// ===== design/mtt_dp.sv =====
// mtt_dp: timer state, interval multiplier, serial divider and result word.
// Depends on mtt_pkg for widths and command/status bundles.

module mtt_dp
    import mtt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [REQ_W-1:0]  s_interval_usec,
    input  logic              cfg_we,
    input  logic [CPU_W-1:0]  cfg_wdata,
    output logic [ELAP_W-1:0] m_elapsed_usec,
    output logic              m_irq_pending,
    output logic              m_rejected
);

    // Control state
    logic [CPU_W-1:0]     cpu_reg, cpu_next;
    logic [REQ_W-1:0]     interval_reg, interval_next;
    logic [CNT_W-1:0]     reload_reg, reload_next;
    logic [CNT_W-1:0]     down_reg, down_next;
    logic                 running_reg, running_next;
    logic                 pending_reg, pending_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;

    // Payload registers
    logic [REQ_W-1:0]     req_reg;
    logic [MUL_W-1:0]     prod_reg;
    logic [CNT_W-1:0]     cyc_reg;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [CPU_W-1:0]     rem_reg, rem_next;
    logic [ELAP_W-1:0]    elap_reg;
    logic                 irq_reg;
    logic                 rej_reg;

    logic [CPU_W-1:0]     cpu_eff;
    logic [PX_W-1:0]      prod_ext;
    logic                 reject;
    logic [CNT_W-1:0]     reload_new;
    logic [CPU_W:0]       trial;
    logic                 fits;
    logic [QX_W-1:0]      q_ext;
    logic [ELAP_W-1:0]    elap_sat;

    // A zero rate is treated as a rate of one
    assign cpu_eff = (cpu_reg == '0) ? CPU_RESET : cpu_reg;

    // Range check of the registered product
    assign prod_ext   = PX_W'(prod_reg);
    assign reject     = (req_reg == '0) || (|prod_ext[PX_W-1:CNT_W]);
    assign reload_new = CNT_W'(prod_ext - PX_W'(1));

    // One restoring divide step
    assign trial = {rem_reg, quot_reg[DIV_W-1]};
    assign fits  = trial >= {1'b0, cpu_eff};

    // Saturate the quotient to the result width
    assign q_ext    = QX_W'(quot_reg);
    assign elap_sat = (|q_ext[QX_W-1:ELAP_W]) ? '1 : q_ext[ELAP_W-1:0];

    assign sts.div_last = (dcnt_reg == DIV_CNT_W'(DIV_W - 1));

    // Timer state updates
    always_comb begin
        cpu_next      = cpu_reg;
        interval_next = interval_reg;
        reload_next   = reload_reg;
        down_next     = down_reg;
        running_next  = running_reg;
        pending_next  = pending_reg;
        if (cfg_we) begin
            cpu_next = cfg_wdata;
        end
        if (cmd.tick && running_reg) begin
            if (down_reg == '0) begin
                down_next    = reload_reg;
                pending_next = 1'b1;
            end else begin
                down_next = down_reg - CNT_W'(1);
            end
        end
        if (cmd.ack) begin
            pending_next = 1'b0;
        end
        if (cmd.set_commit && !reject && (req_reg != interval_reg)) begin
            interval_next = req_reg;
            reload_next   = reload_new;
            down_next     = reload_new;
            running_next  = 1'b1;
        end
    end

    // Divider sequencing
    always_comb begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dcnt_next = dcnt_reg;
        if (cmd.rd_adjust) begin
            if (pending_reg && (cyc_reg < (reload_reg >> 1))) begin
                quot_next = DIV_W'(cyc_reg) + DIV_W'(reload_reg);
            end else begin
                quot_next = DIV_W'(cyc_reg);
            end
            rem_next  = '0;
            dcnt_next = '0;
        end else if (cmd.div_step) begin
            quot_next = {quot_reg[DIV_W-2:0], fits};
            rem_next  = fits ? CPU_W'(trial - {1'b0, cpu_eff}) : trial[CPU_W-1:0];
            dcnt_next = dcnt_reg + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cpu_reg      <= CPU_RESET;
            interval_reg <= '0;
            reload_reg   <= '0;
            down_reg     <= '0;
            running_reg  <= 1'b0;
            pending_reg  <= 1'b0;
            dcnt_reg     <= '0;
        end else begin
            cpu_reg      <= cpu_next;
            interval_reg <= interval_next;
            reload_reg   <= reload_next;
            down_reg     <= down_next;
            running_reg  <= running_next;
            pending_reg  <= pending_next;
            dcnt_reg     <= dcnt_next;
        end
    end

    // Capture operands, multiply, and build the result word
    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (cmd.set_load) begin
            req_reg  <= s_interval_usec;
            prod_reg <= MUL_W'(s_interval_usec) * MUL_W'(cpu_eff);
        end
        if (cmd.rd_load) begin
            cyc_reg <= reload_reg - down_reg;
        end
        if (cmd.out_load) begin
            elap_reg <= (cmd.out_sel == OSEL_READ) ? elap_sat : '0;
            rej_reg  <= (cmd.out_sel == OSEL_SET) ? reject : 1'b0;
            irq_reg  <= pending_next;
        end
    end

    assign m_elapsed_usec = elap_reg;
    assign m_irq_pending  = irq_reg;
    assign m_rejected     = rej_reg;

endmodule

// ===== design/microsecond_tick_timer.sv =====
// microsecond_tick_timer: top level joining the controller and the datapath.
// Depends on mtt_pkg, mtt_ctrl and mtt_dp.

// Periodic tick timer with a microsecond interface. Each input word carries
// an operation: a clock tick (op 0) or an interrupt acknowledge (op 3) has
// its result word registered in the cycle after it is taken; a set-interval
// (op 1) registers the interval-by-rate product, then range-checks it and
// reloads once the output register is free; a read of elapsed microseconds
// (op 2) captures and adjusts the elapsed cycle count, then runs the
// restoring divider that retires one quotient bit per cycle. One word is
// worked on at a time; a finished result waits in an output register, and
// the next word is taken as soon as that register is empty or being
// drained. The rate register is written through the cfg channel, which is
// always ready, and should only be written while no operation is in flight.

module microsecond_tick_timer
    import mtt_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [REQ_W-1:0]  s_interval_usec,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [ELAP_W-1:0] m_elapsed_usec,
    output logic              m_irq_pending,
    output logic              m_rejected,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CPU_W-1:0]  cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    mtt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mtt_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_interval_usec (s_interval_usec),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_wdata       (cfg_wdata),
        .m_elapsed_usec  (m_elapsed_usec),
        .m_irq_pending   (m_irq_pending),
        .m_rejected      (m_rejected)
    );

endmodule

// ===== sim/microsecond_tick_timer_tb.sv =====
// microsecond_tick_timer_tb: self-checking bench for the microsecond tick timer.
// Depends on mtt_pkg and microsecond_tick_timer; a built-in timer predictor
// checks every result word.
`timescale 1ns / 1ps

module microsecond_tick_timer_tb
    import mtt_pkg::*;
();

    localparam logic [63:0] CNT_MAX = (64'd1 << CNT_W) - 64'd1;

    typedef struct packed {
        logic [ELAP_W-1:0] elapsed;
        logic              irq;
        logic              rejected;
    } timer_word_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [OP_W-1:0]   s_op;
    logic [REQ_W-1:0]  s_interval_usec;
    logic              m_valid;
    logic              m_ready;
    logic [ELAP_W-1:0] m_elapsed_usec;
    logic              m_irq_pending;
    logic              m_rejected;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CPU_W-1:0]  cfg_wdata;

    // Predicted timer state and rate register
    logic [CPU_W-1:0]  rate_reg = CPU_RESET;
    logic [REQ_W-1:0]  tmr_interval = '0;
    logic [CNT_W-1:0]  tmr_reload = '0;
    logic [CNT_W-1:0]  tmr_count = '0;
    logic              tmr_running = 1'b0;
    logic              tmr_pending = 1'b0;

    timer_word_t expected_words[$];
    timer_word_t want;
    int          err_count = 0;
    bit          idle_on = 1'b1;

    microsecond_tick_timer dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_interval_usec (s_interval_usec),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_elapsed_usec  (m_elapsed_usec),
        .m_irq_pending   (m_irq_pending),
        .m_rejected      (m_rejected),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_wdata       (cfg_wdata)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Advance the predicted timer by one operation and return its result word
    function automatic timer_word_t advance_timer(input logic [OP_W-1:0] op,
                                                  input logic [REQ_W-1:0] usec);
        logic [63:0] rate;
        logic [63:0] prod;
        logic [63:0] cyc;
        logic [63:0] quo;
        timer_word_t w;
        rate = (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
        w = '0;
        case (op)
            OP_TICK: begin
                if (tmr_running) begin
                    if (tmr_count == '0) begin
                        tmr_count = tmr_reload;
                        tmr_pending = 1'b1;
                    end else begin
                        tmr_count = tmr_count - 1'b1;
                    end
                end
            end
            OP_SET: begin
                prod = 64'(usec) * rate;
                if (usec == '0 || prod > CNT_MAX) begin
                    w.rejected = 1'b1;
                end else if (usec != tmr_interval) begin
                    tmr_interval = usec;
                    tmr_reload = CNT_W'(prod - 64'd1);
                    tmr_count = tmr_reload;
                    tmr_running = 1'b1;
                end
            end
            OP_READ: begin
                cyc = 64'(CNT_W'(tmr_reload - tmr_count));
                // an unacknowledged reload counts one more period while cyc is under half the reload
                if (cyc < 64'(tmr_reload) / 64'd2 && tmr_pending)
                    cyc = cyc + 64'(tmr_reload);
                quo = cyc / rate;
                w.elapsed = (quo > 64'hFFFF_FFFF) ? '1 : ELAP_W'(quo);
            end
            default: begin
                tmr_pending = 1'b0;
            end
        endcase
        w.irq = tmr_pending;
        return w;
    endfunction

    // Send one word, predict it once accepted, then maybe hold off
    task automatic send_word(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] usec);
        s_valid <= 1'b1;
        s_op <= op;
        s_interval_usec <= usec;
        do @(posedge aclk); while (!s_ready);
        expected_words.push_back(advance_timer(op, usec));
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    // Drain all results, then write the rate register
    task automatic write_rate(input logic [CPU_W-1:0] value);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate_reg = value;
    endtask

    // Pick one word: mostly ticks, with short intervals so the counter wraps
    task automatic random_word();
        logic [OP_W-1:0]  op;
        logic [REQ_W-1:0] usec;
        logic [63:0]      rate;
        logic [63:0]      fit;
        int               pick;
        int               short_max;
        rate = (rate_reg == '0) ? 64'd1 : 64'(rate_reg);
        fit = CNT_MAX / rate;
        short_max = (48 / int'(rate) > 0) ? 48 / int'(rate) : 1;
        usec = REQ_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 68)
            op = OP_TICK;
        else if (pick < 76)
            op = OP_SET;
        else if (pick < 90)
            op = OP_READ;
        else
            op = OP_ACK;
        if (op == OP_SET) begin
            case ($urandom_range(0, 19))
                0: usec = '0;
                1: ; // keep the full-range value
                2: usec = (fit > 64'h7FFF_FFFF) ? '1 : REQ_W'(fit);
                3: usec = (fit >= 64'h7FFF_FFFF) ? '1 : REQ_W'(fit + 64'd1);
                default: usec = REQ_W'($urandom_range(1, short_max));
            endcase
        end
        send_word(op, usec);
    endtask

    // Stopped timer, zero interval, reload and pending at the default rate
    task automatic test_stopped_timer();
        send_word(OP_TICK, '0);
        send_word(OP_READ, '0);
        send_word(OP_ACK, '0);
        send_word(OP_SET, '0);
        send_word(OP_SET, '1);
        send_word(OP_TICK, '0);
        send_word(OP_READ, '0);
    endtask

    // Short period, repeated same interval, counter wraps to set pending
    task automatic test_reload_and_pending();
        send_word(OP_SET, REQ_W'(3));
        send_word(OP_SET, REQ_W'(3));
        repeat (4) send_word(OP_TICK, '1);
        send_word(OP_READ, '0);
    endtask

    // Largest rate: range limit, then a restart that keeps pending; a rate of
    // zero afterward makes the adjusted read saturate
    task automatic test_saturated_read();
        write_rate('1);
        send_word(OP_SET, REQ_W'(4198405));
        send_word(OP_SET, REQ_W'(4198404));
        repeat (6) send_word(OP_TICK, '0);
        write_rate('0);
        send_word(OP_READ, '0);
        send_word(OP_ACK, '0);
        send_word(OP_READ, '0);
    endtask

    // Random traffic at one rate, idling switched on and off in stretches
    task automatic test_random_traffic(input logic [CPU_W-1:0] rate, input int count);
        write_rate(rate);
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            random_word();
        end
    endtask

    // Back-to-back traffic with both sides always ready
    task automatic test_steady_stream(input int count);
        write_rate(CPU_W'($urandom_range(1, 4)));
        idle_on = 1'b0;
        repeat (count) random_word();
    endtask

    initial begin
        s_valid <= 1'b0;
        s_op <= OP_TICK;
        s_interval_usec <= '0;
        cfg_valid <= 1'b0;
        cfg_wdata <= '0;
        aresetn <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_stopped_timer();
        test_reload_and_pending();
        test_saturated_read();
        test_random_traffic(CPU_W'(1), 250);
        test_random_traffic(CPU_W'(2), 250);
        test_random_traffic(CPU_W'($urandom_range(3, 8)), 250);
        test_random_traffic('0, 250);
        test_random_traffic('1, 250);
        test_random_traffic(CPU_W'($urandom_range(1, 1023)), 250);
        test_steady_stream(300);

        // Drain, then let the block settle
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (48) @(posedge aclk);
        if (err_count == 0 && expected_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Result side: stall in random bursts
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_words.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected word: elapsed %0d irq %0b rejected %0b",
                             m_elapsed_usec, m_irq_pending, m_rejected);
            end else begin
                want = expected_words.pop_front();
                if (m_elapsed_usec !== want.elapsed || m_irq_pending !== want.irq
                        || m_rejected !== want.rejected) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: elapsed %0d/%0d irq %0b/%0b rejected %0b/%0b",
                                 want.elapsed, m_elapsed_usec, want.irq, m_irq_pending,
                                 want.rejected, m_rejected);
                end
            end
        end
    end

    // Hang guard
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
